@@ src/sff_pkg.sv @@
// Shared types, constants and helpers for the stencil framebuffer fill core.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sff_pkg;

    localparam int unsigned MAX_DIM_DEFAULT = 128;

    localparam int unsigned COORD_W   = 8;
    localparam int unsigned CHAN_W    = 8;
    localparam int unsigned FIELD_W   = 5;
    localparam int unsigned COLOR_W   = 3 * FIELD_W;
    localparam int unsigned OP_W      = 3;
    localparam int unsigned CFG_W     = 8;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned S_TDATA_W = 64;
    localparam int unsigned M_TDATA_W = 32;

    localparam logic [OP_W-1:0] OP_SET_COLOR    = 3'd0;
    localparam logic [OP_W-1:0] OP_GET_COLOR    = 3'd1;
    localparam logic [OP_W-1:0] OP_FILL_RECT    = 3'd2;
    localparam logic [OP_W-1:0] OP_STENCIL_RECT = 3'd3;
    localparam logic [OP_W-1:0] OP_SET_STENCIL  = 3'd4;
    localparam logic [OP_W-1:0] OP_GET_STENCIL  = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    typedef struct packed {
        logic load;
        logic setup;
        logic exec;
        logic out_load;
    } sff_cmd_t;

    typedef struct packed {
        logic exec_done;
        logic out_free;
    } sff_status_t;

    function automatic logic [FIELD_W-1:0] pack_channel(input logic [CHAN_W-1:0] value);
        return value[CHAN_W-1:CHAN_W-FIELD_W];
    endfunction

    function automatic logic [CHAN_W-1:0] unpack_channel(input logic [FIELD_W-1:0] field);
        return {field, {(CHAN_W - FIELD_W){1'b1}}};
    endfunction

endpackage

`default_nettype wire

@@ src/sff_ctrl.sv @@
// Controller state machine of the stencil framebuffer fill core.
// Sequences accept, setup, execution and result hand-off; uses sff_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sff_ctrl (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  sff_pkg::sff_status_t status,
    output sff_pkg::sff_cmd_t    cmd
);
    import sff_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SETUP  = 2'd1;
    localparam logic [1:0] ST_EXEC   = 2'd2;
    localparam logic [1:0] ST_RESULT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                if (status.exec_done) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

@@ src/sff_dp.sv @@
// Datapath of the stencil framebuffer fill core: configuration registers,
// request registers, address unit, rectangle walker, pixel memories and result register.
// Uses sff_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sff_dp #(
    parameter int unsigned MAX_DIM = sff_pkg::MAX_DIM_DEFAULT
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  cfg_we,
    input  wire  [sff_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire  [sff_pkg::CFG_W-1:0]            cfg_wdata,
    input  wire  [sff_pkg::S_TDATA_W-1:0]        s_tdata,
    input  wire  [sff_pkg::OP_W-1:0]             s_tuser,
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    output logic [sff_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic                                 m_tuser,
    input  sff_pkg::sff_cmd_t                    cmd,
    output sff_pkg::sff_status_t                 status
);
    import sff_pkg::*;

    localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [COORD_W-1:0] MAX_DIM_C = COORD_W'(MAX_DIM);

    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    logic [COORD_W-1:0] w_act;
    logic [COORD_W-1:0] h_act;

    logic [OP_W-1:0]    op_reg;
    logic [COORD_W-1:0] x0_reg;
    logic [COORD_W-1:0] x_end_reg;
    logic [COORD_W-1:0] y_end_reg;
    logic [COORD_W-1:0] x_cnt_reg;
    logic [COORD_W-1:0] y_cnt_reg;
    logic [COORD_W-1:0] xe_reg;
    logic [COORD_W-1:0] ye_reg;
    logic [COLOR_W-1:0] color_reg;
    logic               solid_reg;
    logic               inside_reg;
    logic               empty_reg;
    logic [AW-1:0]      base_reg;

    logic [COORD_W-1:0]   xe_next;
    logic [COORD_W-1:0]   ye_next;
    logic [2*COORD_W-1:0] base_prod;
    logic [AW-1:0]        addr;
    logic                 is_rect;
    logic                 x_last;
    logic                 y_last;
    logic                 wr_color;
    logic                 wr_stencil;
    logic                 rd_en;

    logic [COLOR_W-1:0] color_mem [DEPTH];
    logic               stencil_mem [DEPTH];
    logic [COLOR_W-1:0] color_rd_reg;
    logic               stencil_rd_reg;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;
    logic [CHAN_W-1:0]    red_res;
    logic [CHAN_W-1:0]    green_res;
    logic [CHAN_W-1:0]    blue_res;
    logic                 solid_res;
    logic                 oob_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= '0;
            height_reg <= '0;
        end else if (cfg_we) begin
            if (cfg_index == CFG_IMAGE_WIDTH) begin
                width_reg <= cfg_wdata;
            end else if (cfg_index == CFG_IMAGE_HEIGHT) begin
                height_reg <= cfg_wdata;
            end
        end
    end

    assign w_act = (width_reg > MAX_DIM_C) ? MAX_DIM_C : width_reg;
    assign h_act = (height_reg > MAX_DIM_C) ? MAX_DIM_C : height_reg;

    assign xe_next   = (x_end_reg < w_act) ? x_end_reg : w_act;
    assign ye_next   = (y_end_reg < h_act) ? y_end_reg : h_act;
    assign base_prod = (2*COORD_W)'(w_act) * (2*COORD_W)'(y_cnt_reg);
    assign addr      = base_reg + AW'(x_cnt_reg);

    assign is_rect = (op_reg == OP_FILL_RECT) || (op_reg == OP_STENCIL_RECT);
    assign x_last  = ({1'b0, x_cnt_reg} + 9'd1) == {1'b0, xe_reg};
    assign y_last  = ({1'b0, y_cnt_reg} + 9'd1) == {1'b0, ye_reg};

    assign wr_color = cmd.exec &&
        (((op_reg == OP_SET_COLOR) && inside_reg) ||
         ((op_reg == OP_FILL_RECT) && !empty_reg));
    assign wr_stencil = cmd.exec &&
        ((((op_reg == OP_SET_COLOR) || (op_reg == OP_SET_STENCIL)) && inside_reg) ||
         (is_rect && !empty_reg));
    assign rd_en = cmd.exec && inside_reg &&
        ((op_reg == OP_GET_COLOR) || (op_reg == OP_GET_STENCIL));

    assign status.exec_done = !(is_rect && !empty_reg) || (x_last && y_last);
    assign status.out_free  = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= s_tuser;
            x0_reg    <= s_tdata[7:0];
            x_cnt_reg <= s_tdata[7:0];
            y_cnt_reg <= s_tdata[15:8];
            x_end_reg <= s_tdata[23:16];
            y_end_reg <= s_tdata[31:24];
            color_reg <= {pack_channel(s_tdata[55:48]), pack_channel(s_tdata[47:40]),
                          pack_channel(s_tdata[39:32])};
            solid_reg <= s_tdata[56];
        end else if (cmd.setup) begin
            xe_reg     <= xe_next;
            ye_reg     <= ye_next;
            empty_reg  <= (x0_reg >= xe_next) || (y_cnt_reg >= ye_next);
            inside_reg <= (x_cnt_reg < w_act) && (y_cnt_reg < h_act);
            base_reg   <= base_prod[AW-1:0];
        end else if (cmd.exec && is_rect && !empty_reg) begin
            if (x_last) begin
                x_cnt_reg <= x0_reg;
                y_cnt_reg <= y_cnt_reg + 8'd1;
                base_reg  <= base_reg + AW'(w_act);
            end else begin
                x_cnt_reg <= x_cnt_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_color) begin
            color_mem[addr] <= color_reg;
        end
        if (rd_en) begin
            color_rd_reg <= color_mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_stencil) begin
            stencil_mem[addr] <= solid_reg;
        end
        if (rd_en) begin
            stencil_rd_reg <= stencil_mem[addr];
        end
    end

    always_comb begin
        red_res   = '0;
        green_res = '0;
        blue_res  = '0;
        solid_res = 1'b0;
        oob_res   = 1'b0;
        unique case (op_reg)
            OP_GET_COLOR: begin
                if (inside_reg) begin
                    red_res   = unpack_channel(color_rd_reg[FIELD_W-1:0]);
                    green_res = unpack_channel(color_rd_reg[2*FIELD_W-1:FIELD_W]);
                    blue_res  = unpack_channel(color_rd_reg[3*FIELD_W-1:2*FIELD_W]);
                    solid_res = stencil_rd_reg;
                end else begin
                    oob_res = 1'b1;
                end
            end
            OP_GET_STENCIL: begin
                if (inside_reg) begin
                    solid_res = stencil_rd_reg;
                end else begin
                    oob_res = 1'b1;
                end
            end
            OP_SET_COLOR, OP_SET_STENCIL: begin
                oob_res = !inside_reg;
            end
            default: begin
                oob_res = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= M_TDATA_W'({solid_res, blue_res, green_res, red_res});
            m_tuser_reg <= oob_res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

@@ src/stencil_framebuffer_fill_core.sv @@
// Top level of the stencil framebuffer fill core.
// Joins sff_ctrl and sff_dp; uses sff_pkg.
//
// The block holds a MAX_DIM by MAX_DIM framebuffer of 16-bit pixels: a stencil
// bit and three 5-bit color fields. Requests arrive on the s_ channel with the
// opcode on s_tuser and the coordinates and color on s_tdata. Every request
// yields exactly one result on the m_ channel; m_tuser flags a point access
// outside the image. The active image size is set through the cfg_ write port;
// the user must write it only while the block is idle; the block does not enforce this.
// A point request passes from its acceptance to the result register through
// setup with the address multiply, one memory access, and the result
// hand-off. A rectangle request passes through setup, a walk in which the
// walker writes one pixel per cycle into the memory, and the result hand-off;
// an empty rectangle writes no pixel. A new request is accepted in the cycle after
// the previous one has moved into the result register, so one stalled result
// does not block the next request. If the result register is still full when a
// request finishes, the block waits until m_tready frees it. Reset clears the
// control state and the image size registers; the pixel memory is not cleared
// and holds no defined value until written.
`timescale 1ns / 1ps
`default_nettype none

module stencil_framebuffer_fill_core #(
    parameter int unsigned MAX_DIM = sff_pkg::MAX_DIM_DEFAULT
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            cfg_we,
    input  wire  [sff_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire  [sff_pkg::CFG_W-1:0]      cfg_wdata,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    // From bit 0: x_start[7:0], y_start[15:8], x_end[23:16], y_end[31:24],
    // red_in[39:32], green_in[47:40], blue_in[55:48], solid_in[56], zeros.
    input  wire  [sff_pkg::S_TDATA_W-1:0]  s_tdata,
    // From bit 0: opcode[2:0].
    input  wire  [sff_pkg::OP_W-1:0]       s_tuser,
    output logic                           m_tvalid,
    input  wire                            m_tready,
    // From bit 0: red_out[7:0], green_out[15:8], blue_out[23:16], solid_out[24], zeros.
    output logic [sff_pkg::M_TDATA_W-1:0]  m_tdata,
    // From bit 0: out_of_bounds[0].
    output logic                           m_tuser
);
    import sff_pkg::*;

    sff_cmd_t    cmd;
    sff_status_t status;

    sff_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sff_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );

    a_one_request_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("A second request was accepted while one was in progress.");

    a_out_of_bounds_clears_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("An out-of-bounds result carries nonzero data.");

    a_result_load_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("A result was loaded over one that was not yet taken.");

endmodule

`default_nettype wire

@@ tb/tb_stencil_framebuffer_fill_core.sv @@
// Self-checking testbench for stencil_framebuffer_fill_core: point and rectangle requests
// are checked against a framebuffer predictor kept in a small scoreboard class.
// Depends on sff_pkg and the core; needs no files or arguments.
`timescale 1ns / 1ps

module tb_stencil_framebuffer_fill_core;
    import sff_pkg::*;

    localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;
    localparam int unsigned STORE_WORDS = 16384;
    localparam int unsigned CYCLE_LIMIT = 4000000;

    class frame_scoreboard;
        typedef struct {
            bit [7:0] red;
            bit [7:0] green;
            bit [7:0] blue;
            bit       solid;
            bit       oob;
        } pixel_answer_t;

        bit [15:0]     pixels [STORE_WORDS];
        int unsigned   act_w;
        int unsigned   act_h;
        pixel_answer_t answers [$];
        int unsigned   errors;
        int unsigned   results_seen;

        function void resize(bit [7:0] w, bit [7:0] h);
            act_w = (w > 128) ? 128 : w;
            act_h = (h > 128) ? 128 : h;
        endfunction

        function int pending();
            return answers.size();
        endfunction

        function bit [7:0] widen(bit [4:0] f);
            return 8'(int'(f) * 8 + 7);
        endfunction

        function int unsigned addr(int unsigned x, int unsigned y);
            return (x + act_w * y) % STORE_WORDS;
        endfunction

        function void note_request(bit [2:0] op, bit [7:0] x0, bit [7:0] y0, bit [7:0] x1,
                                   bit [7:0] y1, bit [7:0] r, bit [7:0] g, bit [7:0] b,
                                   bit s);
            pixel_answer_t ans;
            bit [15:0]     word;
            bit [15:0]     p;
            int unsigned   a;
            int unsigned   xe;
            int unsigned   ye;
            ans = '{default: 0};
            word = {s, b[7:3], g[7:3], r[7:3]};
            case (op)
                OP_SET_COLOR, OP_GET_COLOR, OP_SET_STENCIL, OP_GET_STENCIL: begin
                    if (x0 >= act_w || y0 >= act_h) begin
                        ans.oob = 1'b1;
                    end else begin
                        a = addr(x0, y0);
                        p = pixels[a];
                        if (op == OP_SET_COLOR) begin
                            pixels[a] = word;
                        end else if (op == OP_GET_COLOR) begin
                            ans.red   = widen(p[4:0]);
                            ans.green = widen(p[9:5]);
                            ans.blue  = widen(p[14:10]);
                            ans.solid = p[15];
                        end else if (op == OP_SET_STENCIL) begin
                            pixels[a] = {word[15], p[14:0]};
                        end else begin
                            ans.solid = p[15];
                        end
                    end
                end
                OP_FILL_RECT, OP_STENCIL_RECT: begin
                    xe = (x1 < act_w) ? x1 : act_w;
                    ye = (y1 < act_h) ? y1 : act_h;
                    for (int unsigned y = y0; y < ye; y++) begin
                        for (int unsigned x = x0; x < xe; x++) begin
                            a = addr(x, y);
                            if (op == OP_FILL_RECT) begin
                                pixels[a] = word;
                            end else begin
                                pixels[a] = {word[15], pixels[a][14:0]};
                            end
                        end
                    end
                end
                default: ;
            endcase
            answers.push_back(ans);
        endfunction

        task report_mismatch(string what, int unsigned got, int unsigned want);
            $display("mismatch on result %0d: %s got 0x%0h expected 0x%0h",
                     results_seen, what, got, want);
            errors++;
        endtask

        task check_result(bit [31:0] data, bit oob);
            pixel_answer_t ans;
            results_seen++;
            if (answers.size() == 0) begin
                report_mismatch("result with no request pending", data, 0);
            end else begin
                ans = answers.pop_front();
                if (data[7:0] != ans.red)
                    report_mismatch("red_out", 32'(data[7:0]), 32'(ans.red));
                if (data[15:8] != ans.green)
                    report_mismatch("green_out", 32'(data[15:8]), 32'(ans.green));
                if (data[23:16] != ans.blue)
                    report_mismatch("blue_out", 32'(data[23:16]), 32'(ans.blue));
                if (data[24] != ans.solid)
                    report_mismatch("solid_out", 32'(data[24]), 32'(ans.solid));
                if (oob != ans.oob)
                    report_mismatch("out_of_bounds", 32'(oob), 32'(ans.oob));
            end
        endtask
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [OP_W-1:0]       s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;

    frame_scoreboard sb = new();
    int unsigned     send_idle = 26;
    int unsigned     recv_idle = 69;
    int unsigned     cycles = 0;

    stencil_framebuffer_fill_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata, m_tuser);
        end
    end

    task send_request(input logic [OP_W-1:0] op, input logic [7:0] x0, input logic [7:0] y0,
                      input logic [7:0] x1, input logic [7:0] y1, input logic [7:0] r,
                      input logic [7:0] g, input logic [7:0] b, input logic s);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'b0, s, b, g, r, y1, x1, y0, x0};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(op, x0, y0, x1, y1, r, g, b, s);
    endtask

    task drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task set_image_size(input logic [7:0] w, input logic [7:0] h);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_wdata <= w;
        @(posedge aclk);
        cfg_index <= CFG_IMAGE_HEIGHT;
        cfg_wdata <= h;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.resize(w, h);
    endtask

    task random_request();
        logic [OP_W-1:0] ops [6];
        logic [OP_W-1:0] op;
        logic [7:0]      x0;
        logic [7:0]      y0;
        logic [7:0]      x1;
        logic [7:0]      y1;
        int unsigned     w;
        int unsigned     h;
        int unsigned     pick;
        ops = '{OP_SET_COLOR, OP_GET_COLOR, OP_FILL_RECT, OP_STENCIL_RECT,
                OP_SET_STENCIL, OP_GET_STENCIL};
        w = sb.act_w;
        h = sb.act_h;
        pick = $urandom_range(99);
        if (pick < 3) begin
            op = pick[0] ? OP_RSVD7 : OP_RSVD6;
        end else begin
            op = ops[$urandom_range(5)];
        end
        x0 = 8'($urandom);
        y0 = 8'($urandom);
        x1 = 8'($urandom);
        y1 = 8'($urandom);
        if (op == OP_FILL_RECT || op == OP_STENCIL_RECT) begin
            if ($urandom_range(49) != 0) begin
                x0 = 8'($urandom_range(w));
                y0 = 8'($urandom_range(h));
                x1 = 8'(32'(x0) + $urandom_range(9) - 2);
                y1 = 8'(32'(y0) + $urandom_range(9) - 2);
            end
        end else if (w != 0 && h != 0 && $urandom_range(99) >= 12) begin
            if ($urandom_range(1) != 0) begin
                x0 = 8'($urandom_range(((w < 6) ? w : 6) - 1));
                y0 = 8'($urandom_range(((h < 6) ? h : 6) - 1));
            end else begin
                x0 = 8'($urandom_range(w - 1));
                y0 = 8'($urandom_range(h - 1));
            end
        end
        send_request(op, x0, y0, x1, y1, 8'($urandom), 8'($urandom), 8'($urandom),
                     1'($urandom));
    endtask

    initial begin
        logic [7:0]  seg_w [9];
        logic [7:0]  seg_h [9];
        int unsigned seg_n [9];
        seg_w = '{128, 1, 0, 37, 1, 128, 255, 100, 129};
        seg_h = '{128, 1, 64, 5, 128, 1, 200, 77, 3};
        seg_n = '{180, 180, 30, 180, 180, 180, 180, 180, 180};

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // At the reset size every point is outside and every rectangle is empty.
        send_request(OP_GET_COLOR, 0, 0, 0, 0, 0, 0, 0, 0);
        send_request(OP_FILL_RECT, 0, 0, 255, 255, 255, 255, 255, 1);
        drain_results();
        set_image_size(255, 128);

        // Fill the whole store first so that no later access reads an unwritten word.
        send_request(OP_FILL_RECT, 0, 0, 255, 255, 255, 0, 128, 1);
        send_request(OP_GET_COLOR, 127, 127, 0, 0, 0, 0, 0, 0);
        send_request(OP_SET_COLOR, 0, 0, 0, 0, 0, 255, 7, 0);
        send_request(OP_GET_COLOR, 0, 0, 0, 0, 0, 0, 0, 0);
        send_request(OP_SET_COLOR, 127, 0, 255, 255, 8, 16, 248, 1);
        send_request(OP_GET_COLOR, 127, 0, 0, 0, 0, 0, 0, 0);
        send_request(OP_SET_COLOR, 128, 0, 0, 0, 255, 255, 255, 1);
        send_request(OP_GET_COLOR, 0, 128, 0, 0, 0, 0, 0, 0);
        send_request(OP_SET_STENCIL, 255, 255, 0, 0, 0, 0, 0, 0);
        send_request(OP_GET_STENCIL, 200, 3, 0, 0, 0, 0, 0, 0);
        send_request(OP_SET_STENCIL, 5, 5, 0, 0, 255, 255, 255, 0);
        send_request(OP_GET_COLOR, 5, 5, 0, 0, 0, 0, 0, 0);
        send_request(OP_GET_STENCIL, 5, 5, 0, 0, 0, 0, 0, 0);
        send_request(OP_STENCIL_RECT, 0, 0, 4, 4, 255, 255, 255, 0);
        send_request(OP_GET_COLOR, 3, 3, 0, 0, 0, 0, 0, 0);
        send_request(OP_GET_STENCIL, 4, 4, 0, 0, 0, 0, 0, 0);
        send_request(OP_FILL_RECT, 10, 10, 5, 5, 0, 0, 0, 0);
        send_request(OP_GET_COLOR, 7, 7, 0, 0, 0, 0, 0, 0);
        send_request(OP_FILL_RECT, 120, 120, 255, 255, 77, 150, 33, 0);
        send_request(OP_GET_COLOR, 127, 127, 0, 0, 0, 0, 0, 0);
        send_request(OP_RSVD6, 255, 255, 255, 255, 255, 255, 255, 1);
        send_request(OP_RSVD7, 1, 1, 200, 200, 255, 255, 255, 1);
        send_request(OP_STENCIL_RECT, 0, 0, 0, 0, 0, 0, 0, 1);

        for (int i = 0; i < 9; i++) begin
            drain_results();
            set_image_size(seg_w[i], seg_h[i]);
            if (i < 3) begin
                send_idle = 26;
                recv_idle = 69;
            end else if (i < 6) begin
                send_idle = 69;
                recv_idle = 26;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            for (int n = 0; n < seg_n[i]; n++) begin
                if ($urandom_range(149) == 0) drain_results();
                random_request();
            end
        end

        drain_results();
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
